@@ design/vtsr_pkg.sv @@
// Shared types and constants for the VLAN tag swap rewriter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vtsr_pkg;

  localparam int DEPTH      = 18;  // tagged header length, also output chain length
  localparam int ETH_HDR    = 14;
  localparam int MAC_LEN    = 12;
  localparam int POS_W      = 5;

  localparam logic [15:0] TPID_CTAG = 16'h8100;
  localparam logic [15:0] TPID_STAG = 16'h88A8;

  // One item of the output chain.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;   // last byte of the rewritten frame
    logic       rl;    // last result caused by one input item
  } entry_t;

  // Per-cell control for one clock.
  typedef struct packed {
    logic load;   // take the burst entry
    logic push;   // take the single pass-through entry
    logic pop;    // shift toward the output
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/vlan_tag_swap_rewriter.sv @@
// Top level of the 802.1Q tag insert / strip rewriter: header capture, burst
// build and the output cell chain. Depends on vtsr_pkg and vtsr_cell.
//
//  channel  | signals                        | contents
//  ---------+--------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata s_tlast | frame byte, frame end
//  output   | m_tvalid m_tready m_tdata m_tlast m_tuser | byte, frame end, run last
//  config   | cfg_we cfg_data                | push_tci
//
// Pass-through bytes enter the chain behind pending items while the chain has
// room. A header byte is taken only when the chain drains this cycle; a burst
// (up to 18 items) loads the 18-cell chain at once and leaves one item a cycle
// while the output is ready. The first byte of the next frame waits for the
// chain to drain.
// Reset (rst, synchronous) empties the chain and restarts at a frame start.
`timescale 1ns / 1ps
`default_nettype none

module vlan_tag_swap_rewriter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
  input  wire logic        s_tlast,   // frame_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tlast,   // out_frame_end
  output logic             m_tuser,   // [0] run_last
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data   // [15:0] push_tci
);
  import vtsr_pkg::*;

  logic [15:0]      push_tci;
  logic [7:0]       hs [DEPTH];
  logic [7:0]       hs_eff [DEPTH];
  logic [POS_W-1:0] pos, pos_next, pos_new;
  logic             pass, pass_next;
  logic [POS_W-1:0] cnt, cnt_next, free, burst_n;
  logic             hdr_mode, acc, pop, do_load, do_push, end_flag;
  logic [15:0]      ether_type;
  logic [7:0]       burst_data [DEPTH];
  entry_t           burst_ent [DEPTH];
  logic             burst_vld [DEPTH];
  entry_t           push_ent;
  entry_t           ent [DEPTH];
  logic             vld [DEPTH];
  entry_t           right_ent [DEPTH];
  logic             right_vld [DEPTH];
  cell_ctl_t        ctl [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      push_tci <= 16'd1;
    end else if (cfg_we) begin
      push_tci <= cfg_data;
    end
  end

  assign pop      = vld[0] & m_tready;
  assign free     = cnt - {{(POS_W-1){1'b0}}, pop};
  assign hdr_mode = !pass && (pos < POS_W'(DEPTH));
  assign s_tready = hdr_mode ? (free == '0) : (free < POS_W'(DEPTH));
  assign acc      = s_tvalid & s_tready;
  assign pos_new  = pos + POS_W'(1);

  // Header bytes seen so far, with the arriving byte already in place.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hs_eff[i] = (POS_W'(i) == pos) ? s_tdata : hs[i];
    end
  end
  assign ether_type = {hs_eff[12], hs_eff[13]};

  always_comb begin
    pos_next = pos;
    pass_next = pass;
    do_load = 1'b0;
    do_push = 1'b0;
    burst_n = '0;
    end_flag = s_tlast;
    for (int i = 0; i < DEPTH; i++) begin
      burst_data[i] = hs_eff[i];
    end
    if (acc) begin
      if (!hdr_mode) begin
        do_push = 1'b1;
        if (s_tlast) begin
          pos_next = '0;
          pass_next = 1'b0;
        end else begin
          pass_next = 1'b1;
        end
      end else begin
        pos_next = pos_new;
        if (pos_new == POS_W'(ETH_HDR) && ether_type != TPID_CTAG &&
            ether_type != TPID_STAG) begin
          // insert a tag after the MAC addresses
          do_load = 1'b1;
          burst_n = POS_W'(DEPTH);
          burst_data[MAC_LEN]     = TPID_CTAG[15:8];
          burst_data[MAC_LEN + 1] = TPID_CTAG[7:0];
          burst_data[MAC_LEN + 2] = push_tci[15:8];
          burst_data[MAC_LEN + 3] = push_tci[7:0];
          burst_data[MAC_LEN + 4] = hs_eff[12];
          burst_data[MAC_LEN + 5] = hs_eff[13];
        end else if (pos_new == POS_W'(DEPTH)) begin
          // strip the outer tag, keep the inner ethertype
          do_load = 1'b1;
          burst_n = POS_W'(ETH_HDR);
          burst_data[MAC_LEN]     = hs_eff[16];
          burst_data[MAC_LEN + 1] = hs_eff[17];
        end else if (s_tlast) begin
          // short frame: flush what was buffered unchanged
          do_load = 1'b1;
          burst_n = pos_new;
        end
        if (do_load) begin
          if (s_tlast) begin
            pos_next = '0;
            pass_next = 1'b0;
          end else begin
            pass_next = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      burst_vld[i]      = POS_W'(i) < burst_n;
      burst_ent[i].data = burst_data[i];
      burst_ent[i].rl   = POS_W'(i + 1) == burst_n;
      burst_ent[i].fin  = (POS_W'(i + 1) == burst_n) & end_flag;
    end
  end

  assign push_ent.data = s_tdata;
  assign push_ent.fin  = s_tlast;
  assign push_ent.rl   = 1'b1;

  assign cnt_next = do_load ? burst_n : (free + {{(POS_W-1){1'b0}}, do_push});

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      pass <= 1'b0;
      cnt  <= '0;
    end else begin
      pos  <= pos_next;
      pass <= pass_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (acc && hdr_mode && POS_W'(i) == pos) begin
        hs[i] <= s_tdata;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_chain
      if (g == DEPTH - 1) begin : g_tail
        assign right_ent[g] = '0;
        assign right_vld[g] = 1'b0;
      end else begin : g_mid
        assign right_ent[g] = ent[g + 1];
        assign right_vld[g] = vld[g + 1];
      end

      assign ctl[g].load = do_load;
      assign ctl[g].push = do_push && (free == POS_W'(g));
      assign ctl[g].pop  = pop;

      vtsr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[g]),
        .load_ent  (burst_ent[g]),
        .load_vld  (burst_vld[g]),
        .push_ent  (push_ent),
        .right_ent (right_ent[g]),
        .right_vld (right_vld[g]),
        .ent       (ent[g]),
        .vld       (vld[g])
      );
    end
  endgenerate

  assign m_tvalid = vld[0];
  assign m_tdata  = ent[0].data;
  assign m_tlast  = ent[0].fin;
  assign m_tuser  = ent[0].rl;

endmodule

`default_nettype wire

@@ design/vtsr_cell.sv @@
// One cell of the output chain: holds one pending item and shifts it toward
// the output. Depends on vtsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtsr_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vtsr_pkg::cell_ctl_t ctl,
  input  wire vtsr_pkg::entry_t  load_ent,
  input  wire logic              load_vld,
  input  wire vtsr_pkg::entry_t  push_ent,
  input  wire vtsr_pkg::entry_t  right_ent,
  input  wire logic              right_vld,
  output vtsr_pkg::entry_t       ent,
  output logic                   vld
);
  import vtsr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.load) begin
      vld <= load_vld;
    end else if (ctl.push) begin
      vld <= 1'b1;
    end else if (ctl.pop) begin
      vld <= right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent <= load_ent;
    end else if (ctl.push) begin
      ent <= push_ent;
    end else if (ctl.pop) begin
      ent <= right_ent;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_vlan_tag_swap_rewriter.sv @@
// Self-checking testbench for vlan_tag_swap_rewriter: streams Ethernet frames
// byte by byte, predicts the tag insert / strip output and checks every item.
// Depends on vtsr_pkg and the vlan_tag_swap_rewriter RTL.
`timescale 1ns / 1ps

module tb_vlan_tag_swap_rewriter;
  import vtsr_pkg::*;

  localparam int          RANDOM_BYTES = 48;
  localparam int          SETTLE_CYCLES = 40;   // above the 18-cell chain drain
  localparam int          HOLD_CYCLES = 300;
  localparam logic [15:0] TCI_RESET = 16'h0001;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we;
  logic [15:0] cfg_data;

  vlan_tag_swap_rewriter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Rewriter state mirrored by the predictor.
  logic [7:0]       hdr_buf [DEPTH];
  logic [POS_W-1:0] hdr_cnt;
  logic             in_body;
  logic [15:0]      tci_now;

  entry_t rewritten_q[$];
  int     fail_count;
  int     bytes_sent;
  int     burst_left;
  bit     gaps_on;
  int     hold_token;

  // Work out the output items caused by one accepted frame byte.
  function automatic void predict_rewrite(input logic [7:0] b, input logic last);
    logic [7:0]  outs[$];
    logic [15:0] etype;
    entry_t      e;
    bit          decided;
    decided = 1'b0;
    if (in_body || hdr_cnt >= DEPTH) begin
      outs.push_back(b);
      decided = 1'b1;
    end else begin
      hdr_buf[hdr_cnt] = b;
      hdr_cnt = hdr_cnt + 1'b1;
      if (hdr_cnt == ETH_HDR) begin
        etype = {hdr_buf[12], hdr_buf[13]};
        if (etype != TPID_CTAG && etype != TPID_STAG) begin
          for (int i = 0; i < MAC_LEN; i++) outs.push_back(hdr_buf[i]);
          outs.push_back(TPID_CTAG[15:8]);
          outs.push_back(TPID_CTAG[7:0]);
          outs.push_back(tci_now[15:8]);
          outs.push_back(tci_now[7:0]);
          outs.push_back(hdr_buf[12]);
          outs.push_back(hdr_buf[13]);
          decided = 1'b1;
        end
      end else if (hdr_cnt == DEPTH) begin
        // strip the outer tag, keep the inner ethertype
        for (int i = 0; i < MAC_LEN; i++) outs.push_back(hdr_buf[i]);
        outs.push_back(hdr_buf[16]);
        outs.push_back(hdr_buf[17]);
        decided = 1'b1;
      end
      // frame ended before a header decision: replay what was buffered
      if (!decided && last) begin
        for (int i = 0; i < hdr_cnt; i++) outs.push_back(hdr_buf[i]);
      end
    end
    foreach (outs[i]) begin
      e.data = outs[i];
      e.fin  = (i == outs.size() - 1) ? last : 1'b0;
      e.rl   = (i == outs.size() - 1);
      rewritten_q.push_back(e);
    end
    if (last) begin
      hdr_cnt = '0;
      in_body = 1'b0;
    end else if (decided) begin
      in_body = 1'b1;
    end
  endfunction

  // Offer one byte; return once it has been accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    predict_rewrite(b, last);
    bytes_sent++;
  endtask

  // Send a frame of len bytes with the given ethertype; other bytes random.
  task automatic send_frame(input int len, input logic [15:0] etype);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 12) b = etype[15:8];
      if (i == 13) b = etype[7:0];
      send_byte(b, i == len - 1);
    end
  endtask

  // Stop offering and wait until every predicted item has come out.
  task automatic drain_outputs();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (rewritten_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_tci(input logic [15:0] v);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we  = 1'b0;
    tci_now = v;
  endtask

  function automatic logic [15:0] random_tag_type();
    return $urandom_range(0, 1) ? TPID_CTAG : TPID_STAG;
  endfunction

  // Random ethertype that is not a tag type.
  function automatic logic [15:0] random_plain_type();
    logic [15:0] t;
    do t = 16'($urandom_range(0, 16'hFFFF)); while (t == TPID_CTAG || t == TPID_STAG);
    return t;
  endfunction

  task automatic test_reset_tci();
    send_frame(ETH_HDR, 16'h0800);   // header-only frame still gets a tag
    send_frame(1, 16'h0000);
    send_byte(8'hFF, 1'b1);
    drain_outputs();
  endtask

  task automatic test_tag_strip();
    send_frame(DEPTH, TPID_CTAG);    // stripped to a bare header
    send_frame(DEPTH + 3, TPID_STAG);
    send_frame(ETH_HDR + 2, 16'h8101);
    drain_outputs();
  endtask

  task automatic test_short_frames();
    send_frame(ETH_HDR - 1, 16'h0000);
    send_frame(ETH_HDR, TPID_CTAG);  // tagged, ends on the ethertype
    send_frame(ETH_HDR + 2, TPID_STAG);
    send_frame(DEPTH - 1, TPID_CTAG);
    drain_outputs();
  endtask

  task automatic test_tci_extremes();
    write_tci(16'hFFFF);
    send_frame(ETH_HDR + 1, 16'h88A9);
    write_tci(16'h0000);
    send_frame(ETH_HDR, 16'hFFFF);
    drain_outputs();
  endtask

  // Stall the receiver for a long stretch while frames keep coming.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_token++;
    send_frame(26, random_plain_type());
    send_frame(22, random_tag_type());
    drain_outputs();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames(input int byte_goal);
    int kind;
    int len;
    int stop_at;
    stop_at = bytes_sent + byte_goal;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 64)
                                         : $urandom_range(ETH_HDR, 30);
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      case (kind)
        0, 1, 2, 3: send_frame(len, random_plain_type());
        4, 5: send_frame(len + 4, TPID_CTAG);
        6, 7: send_frame(len + 4, TPID_STAG);
        8: send_frame($urandom_range(1, DEPTH - 1), random_tag_type());
        default: send_frame($urandom_range(1, 40), 16'($urandom_range(0, 16'hFFFF)));
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: check accepted items, stall on a rotating pattern.
  initial begin
    int rx_cyc;
    int hold_left;
    int hold_seen;
    entry_t want;
    rx_cyc    = 0;
    hold_left = 0;
    hold_seen = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (rewritten_q.size() == 0) begin
          $error("unexpected item: out_byte %02h out_frame_end %0b run_last %0b",
                 m_tdata, m_tlast, m_tuser);
          fail_count++;
        end else begin
          want = rewritten_q.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.fin) begin
            $error("out_frame_end: expected %0b, got %0b", want.fin, m_tlast);
            fail_count++;
          end
          if (m_tuser !== want.rl) begin
            $error("run_last: expected %0b, got %0b", want.rl, m_tuser);
            fail_count++;
          end
        end
      end
      @(negedge clk);
      rx_cyc++;
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        case ((rx_cyc / 97) % 4)
          0: m_tready = 1'b1;
          1: m_tready = (rx_cyc % 4) != 3;
          2: m_tready = ($urandom_range(0, 1) == 1);
          default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #5ms;
    $display("vlan_tag_swap_rewriter verification failed");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    hdr_cnt    = '0;
    in_body    = 1'b0;
    tci_now    = TCI_RESET;
    fail_count = 0;
    bytes_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    hold_token = 0;
    foreach (hdr_buf[i]) hdr_buf[i] = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_reset_tci();
    test_tag_strip();
    test_short_frames();
    test_tci_extremes();
    test_backpressure();
    write_tci(16'($urandom_range(0, 16'hFFFF)));
    test_random_frames(RANDOM_BYTES / 3);
    write_tci(16'hFFFF);
    test_random_frames(RANDOM_BYTES / 3);
    write_tci(16'h0000);
    test_random_frames(RANDOM_BYTES / 3);

    drain_outputs();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("vlan_tag_swap_rewriter verification clean");
    end else begin
      $display("vlan_tag_swap_rewriter verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/vtsr_pkg.sv
design/vtsr_cell.sv
design/vlan_tag_swap_rewriter.sv
dv/tb_vlan_tag_swap_rewriter.sv
